// ----- rtl/cctd_pkg.sv -----
`timescale 1ns / 1ps

package cctd_pkg;

  localparam int unsigned DefTeethPerStep    = 3;
  localparam int unsigned DefCountedPositions = 45;
  localparam int unsigned DefStepDegrees     = 8;

  localparam int unsigned CycleDegrees = 720;
  localparam int unsigned HalfDegrees  = 360;
  localparam int unsigned EarlyRevs    = 100;
  localparam int unsigned SubtoothMax  = 3;

  localparam logic [15:0] FilterReset = 16'd148;

  typedef enum logic [1:0] {
    CFG_TOOTH_FILTER = 2'd0,
    CFG_RESYNC_CAM   = 2'd1,
    CFG_TOOTH_ANGLE  = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_index_e;

  typedef logic [9:0] base_tbl_t [256];

  typedef struct packed {
    logic [7:0]        pos;
    logic              sync;
    logic              rev;
    logic signed [9:0] angle_ofs;
  } angle_req_t;

  // Angle of each position before the tooth one offset, already reduced mod 720.
  function automatic base_tbl_t build_base(int unsigned positions, int unsigned step);
    base_tbl_t   tbl;
    int unsigned p;
    for (int i = 0; i < 256; i++) begin
      p = (i == 0) ? positions : i;
      tbl[i] = 10'(((p - 1) * step) % CycleDegrees);
    end
    return tbl;
  endfunction

endpackage

// ----- rtl/cctd_angle.sv -----
`timescale 1ns / 1ps

module cctd_angle #(
  parameter int unsigned COUNTED_POSITIONS = cctd_pkg::DefCountedPositions,
  parameter int unsigned STEP_DEGREES      = cctd_pkg::DefStepDegrees
) (
  input  cctd_pkg::angle_req_t req_i,
  output logic [10:0]          angle_o
);
  import cctd_pkg::*;

  localparam base_tbl_t BaseTbl = build_base(COUNTED_POSITIONS, STEP_DEGREES);

  logic signed [11:0] sum;
  logic signed [11:0] red;

  always_comb begin
    sum = $signed({2'b00, BaseTbl[req_i.pos]}) + 12'(req_i.angle_ofs)
        + (req_i.rev ? 12'(HalfDegrees) : 12'sd0);
    if (sum < 0) begin
      red = sum + 12'(CycleDegrees);
    end else if (sum >= 12'(2 * CycleDegrees)) begin
      red = sum - 12'(2 * CycleDegrees);
    end else if (sum >= 12'(CycleDegrees)) begin
      red = sum - 12'(CycleDegrees);
    end else begin
      red = sum;
    end
    angle_o = req_i.sync ? red[10:0] : 11'd0;
  end

endmodule

// ----- rtl/crank_cam_tooth_decoder.sv -----
`timescale 1ns / 1ps
// The result is registered and valid in the cycle after the input transfer.
// Throughput: one edge per cycle; the result register decouples the sides, input
// stalls only while a held result is itself stalled.
// Reset (rst_ni low, async): position 255, unsynced, counters and times zero,
// filter 148 us, resync off, tooth one angle 0. No clearing pass.

module crank_cam_tooth_decoder #(
  parameter int unsigned TEETH_PER_STEP    = cctd_pkg::DefTeethPerStep,
  parameter int unsigned COUNTED_POSITIONS = cctd_pkg::DefCountedPositions,
  parameter int unsigned STEP_DEGREES      = cctd_pkg::DefStepDegrees
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [31:0] time_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  tooth_number_o,
  output logic        synced_o,
  output logic        second_revolution_o,
  output logic        counted_tooth_o,
  output logic        tooth_one_seen_o,
  output logic [10:0] crank_angle_o,
  output logic [31:0] last_tooth_time_o,
  output logic [31:0] previous_tooth_time_o,
  output logic [31:0] tooth_one_time_o,
  output logic [31:0] previous_tooth_one_time_o,
  output logic [15:0] revolutions_o
);
  import cctd_pkg::*;

  localparam logic [1:0] Tps = 2'(TEETH_PER_STEP);
  localparam logic [7:0] Cp  = 8'(COUNTED_POSITIONS);

  logic [15:0]       filter_q;
  logic              resync_q;
  logic signed [9:0] angle_ofs_q;

  logic [31:0] lct_q, lct_d;
  logic [1:0]  sub_q, sub_d;
  logic [7:0]  pos_q, pos_d;
  logic        sync_q, sync_d;
  logic        rev_q, rev_d;
  logic [15:0] revs_q, revs_d;
  logic [31:0] last_q, last_d;
  logic [31:0] prev_q, prev_d;
  logic [31:0] one_q, one_d;
  logic [31:0] prev_one_q, prev_one_d;
  logic        counted, wrapped;

  logic        in_xfer;
  logic        ov_q;
  logic [31:0] gap;
  logic [1:0]  sub_inc;
  logic [7:0]  pos_inc;
  angle_req_t  areq;
  logic [10:0] angle;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = ov_q & out_stall_i;
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q    <= FilterReset;
      resync_q    <= 1'b0;
      angle_ofs_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_TOOTH_FILTER: filter_q    <= cfg_data_i;
        CFG_RESYNC_CAM:   resync_q    <= cfg_data_i[0];
        CFG_TOOTH_ANGLE:  angle_ofs_q <= $signed(cfg_data_i[9:0]);
        default: ;
      endcase
    end
  end

  assign gap     = time_us_i - lct_q;
  assign sub_inc = (sub_q < 2'(SubtoothMax)) ? sub_q + 2'd1 : sub_q;
  assign pos_inc = pos_q + 8'd1;

  always_comb begin
    lct_d      = lct_q;
    sub_d      = sub_q;
    pos_d      = pos_q;
    sync_d     = sync_q;
    rev_d      = rev_q;
    revs_d     = revs_q;
    last_d     = last_q;
    prev_d     = prev_q;
    one_d      = one_q;
    prev_one_d = prev_one_q;
    counted    = 1'b0;
    wrapped    = 1'b0;
    if (!mode_i) begin
      if (gap > {16'd0, filter_q} || revs_q == 16'd0) begin
        sub_d = sub_inc;
        if (!sync_q) begin
          last_d = time_us_i;
        end else if (sub_inc >= Tps) begin
          counted = 1'b1;
          lct_d   = time_us_i;
          sub_d   = 2'd0;
          pos_d   = pos_inc;
          if (pos_inc == 8'd1 || pos_inc > Cp) begin
            pos_d      = 8'd1;
            wrapped    = 1'b1;
            prev_one_d = one_q;
            one_d      = time_us_i;
            rev_d      = ~rev_q;
            if (revs_q != 16'hFFFF) begin
              revs_d = revs_q + 16'd1;
            end
          end
          prev_d = last_q;
          last_d = time_us_i;
        end
      end
    end else begin
      if (!sync_q) begin
        pos_d  = 8'd0;
        sync_d = 1'b1;
        sub_d  = 2'(SubtoothMax);
      end else if (resync_q) begin
        pos_d = 8'd0;
        sub_d = 2'(SubtoothMax);
      end else if (revs_q < 16'(EarlyRevs) && pos_q != Cp) begin
        pos_d = 8'd0;
      end
      rev_d = 1'b1;
    end
  end

  assign areq = '{pos: pos_d, sync: sync_d, rev: rev_d, angle_ofs: angle_ofs_q};

  cctd_angle #(
    .COUNTED_POSITIONS(COUNTED_POSITIONS),
    .STEP_DEGREES     (STEP_DEGREES)
  ) u_angle (
    .req_i  (areq),
    .angle_o(angle)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lct_q      <= '0;
      sub_q      <= '0;
      pos_q      <= 8'hFF;
      sync_q     <= 1'b0;
      rev_q      <= 1'b0;
      revs_q     <= '0;
      last_q     <= '0;
      prev_q     <= '0;
      one_q      <= '0;
      prev_one_q <= '0;
      ov_q       <= 1'b0;
    end else begin
      if (in_xfer) begin
        lct_q      <= lct_d;
        sub_q      <= sub_d;
        pos_q      <= pos_d;
        sync_q     <= sync_d;
        rev_q      <= rev_d;
        revs_q     <= revs_d;
        last_q     <= last_d;
        prev_q     <= prev_d;
        one_q      <= one_d;
        prev_one_q <= prev_one_d;
        ov_q       <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      tooth_number_o            <= pos_d;
      synced_o                  <= sync_d;
      second_revolution_o       <= rev_d;
      counted_tooth_o           <= counted;
      tooth_one_seen_o          <= wrapped;
      crank_angle_o             <= angle;
      last_tooth_time_o         <= last_d;
      previous_tooth_time_o     <= prev_d;
      tooth_one_time_o          <= one_d;
      previous_tooth_one_time_o <= prev_one_d;
      revolutions_o             <= revs_d;
    end
  end

`ifndef SYNTHESIS
  a_counted_synced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && counted_tooth_o |-> synced_o)
    else $error("counted tooth while unsynced");

  a_wrap_is_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && tooth_one_seen_o |-> counted_tooth_o && tooth_number_o == 8'd1)
    else $error("wrap without counted tooth one");

  a_unsynced_angle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !synced_o |-> crank_angle_o == 11'd0 && tooth_number_o == 8'hFF)
    else $error("unsynced result carries position");

  a_angle_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> crank_angle_o < 11'(CycleDegrees))
    else $error("angle out of range");

  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q && $stable(crank_angle_o) && $stable(revolutions_o))
    else $error("stalled result changed");
`endif

endmodule
